// ----- hdl/btc_pkg.sv -----
package btc_pkg;

    // Default build parameters
    localparam int FONT_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT_DEF = 256;

    // Field widths
    localparam int MODE_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int WIDX_W    = 13;
    localparam int DATA_W    = 32;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 8;
    localparam int PIXX_W    = 13;
    localparam int PIXY_W    = 14;
    localparam int FONT_W    = 8;
    localparam int COLS_W    = 10;
    localparam int ROWS_W    = 9;
    localparam int CFG_IDX_W = 3;

    // Palette
    localparam int PALETTE_SIZE = 5;
    localparam int PAL_IW       = 3;
    localparam logic [DATA_W-1:0] PALETTE_RESET [PALETTE_SIZE] = '{
        32'h00FF_FFFF, 32'h0091_1900, 32'h00E1_E100, 32'h000A_800A, 32'h0000_0000
    };
    localparam logic [DATA_W-1:0] FORE_RESET = 32'h00FF_FFFF;

    // Item modes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_CHAR    = 3'd0;
    localparam t_mode MODE_FONT    = 3'd1;
    localparam t_mode MODE_PALETTE = 3'd2;
    localparam t_mode MODE_CURSOR  = 3'd3;
    localparam t_mode MODE_FORE    = 3'd4;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TEXT_COLUMNS = 3'd0;
    localparam t_cfg_idx REG_TEXT_ROWS    = 3'd1;
    localparam t_cfg_idx REG_COL_OFFSET   = 3'd2;
    localparam t_cfg_idx REG_ROW_OFFSET   = 3'd3;
    localparam t_cfg_idx REG_BACK_COLOR   = 3'd4;

    localparam logic [COLS_W-1:0] TEXT_COLUMNS_RESET = 10'd128;
    localparam logic [ROWS_W-1:0] TEXT_ROWS_RESET    = 9'd48;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_AT   = 8'h40;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_FOUR = 8'h34;
    localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
        logic              string_end;
        logic [WIDX_W-1:0] write_index;
        logic [DATA_W-1:0] write_data;
        logic [COL_W-1:0]  set_column;
        logic [ROW_W-1:0]  set_row;
    } t_in_item;

    typedef struct packed {
        logic [PIXX_W-1:0] pixel_x;
        logic [PIXY_W-1:0] pixel_y;
        logic [FONT_W-1:0] row_bits;
        logic [DATA_W-1:0] fore_color;
        logic [DATA_W-1:0] back_color;
        logic              last_row;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic read;
        logic load;
        logic y_clr;
        logic y_inc;
        logic cur_step;
        logic slot_b;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_char;
        logic cur_has;
        logic cur_nl;
        logic has_b;
        logic y_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/btc_if.sv -----
// Input item channel
interface btc_in_if;
    import btc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result item channel
interface btc_out_if;
    import btc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/btc_ram.sv -----
module btc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/btc_datapath.sv -----
module btc_datapath #(
    parameter int FONT_HEIGHT = btc_pkg::FONT_HEIGHT_DEF,
    parameter int GLYPH_COUNT = btc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  btc_pkg::t_cmd                   i_cmd,
    output btc_pkg::t_stat                  o_stat,
    input  btc_pkg::t_in_item               i_item,
    input  logic                            i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btc_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output btc_pkg::t_out_item              o_out_item
);
    import btc_pkg::*;

    localparam int FONT_BYTES = GLYPH_COUNT * FONT_HEIGHT;
    localparam int AW = $clog2(FONT_BYTES);
    localparam int YW = $clog2(FONT_HEIGHT);

    // Latched item and configuration
    t_in_item          r_item;
    logic [COLS_W-1:0] r_text_columns;
    logic [ROWS_W-1:0] r_text_rows;
    logic [COL_W-1:0]  r_column_offset;
    logic [ROW_W-1:0]  r_row_offset;
    logic [DATA_W-1:0] r_back_color;

    // Console state
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [DATA_W-1:0] r_fore;
    logic              r_pending;
    logic [DATA_W-1:0] r_palette [PALETTE_SIZE];

    // Per-item plan: up to two characters to put
    logic              r_has_a;
    logic              r_has_b;
    logic [CHAR_W-1:0] r_code_a;
    logic [CHAR_W-1:0] r_code_b;
    logic [YW-1:0]     r_y;

    // Output stage
    logic              r_out_valid;
    t_out_item         r_out_item;

    // Plan decode
    logic              is_digit;
    logic              is_at;
    logic              x_has;
    logic [CHAR_W-1:0] x_code;
    logic              n_has_a;
    logic              n_has_b;
    logic [CHAR_W-1:0] n_code_a;
    logic [CHAR_W-1:0] n_code_b;

    always_comb begin
        is_digit = (r_item.char_code >= CH_ZERO) && (r_item.char_code <= CH_FOUR);
        is_at    = (r_item.char_code == CH_AT);
        x_has    = !is_at || r_item.string_end;
        x_code   = is_at ? CH_AT : r_item.char_code;
        n_has_a  = 1'b0;
        n_has_b  = 1'b0;
        n_code_a = x_code;
        n_code_b = x_code;
        priority if (r_pending && !is_digit) begin
            n_has_a  = 1'b1;
            n_code_a = CH_AT;
            n_has_b  = x_has;
        end else if (r_pending) begin
            n_has_a = 1'b0;
        end else begin
            n_has_a = x_has;
        end
    end

    // Current character and cursor step
    logic [CHAR_W-1:0] cur_code;
    logic              cur_has;
    logic              cur_nl;
    logic              b_drawn;
    logic              y_last;
    logic [ROWS_W-1:0] nl_row9;
    logic [ROW_W-1:0]  nl_row;
    logic [COLS_W-1:0] c10;
    logic [ROW_W-1:0]  rb;
    logic              wrap_col;
    logic [ROWS_W-1:0] r9;
    logic [COL_W-1:0]  step_col;
    logic [ROW_W-1:0]  step_row;

    always_comb begin
        cur_code = i_cmd.slot_b ? r_code_b : r_code_a;
        cur_has  = i_cmd.slot_b ? r_has_b : r_has_a;
        cur_nl   = (cur_code == CH_NL);
        b_drawn  = r_has_b && (r_code_b != CH_NL);
        y_last   = (r_y == YW'(FONT_HEIGHT - 1));

        // newline first advances the row, then both share the column check
        nl_row9  = {1'b0, r_cur_row} + 9'd1;
        nl_row   = ((nl_row9 >= r_text_rows) || (nl_row9 > 9'd255)) ? '0 : nl_row9[ROW_W-1:0];
        c10      = cur_nl ? '0 : ({1'b0, r_cur_col} + 10'd1);
        rb       = cur_nl ? nl_row : r_cur_row;
        wrap_col = (c10 >= r_text_columns) || (c10 > 10'd511);
        r9       = wrap_col ? ({1'b0, rb} + 9'd1) : {1'b0, rb};
        step_col = wrap_col ? '0 : c10[COL_W-1:0];
        step_row = ((r9 >= r_text_rows) || (r9 > 9'd255)) ? '0 : r9[ROW_W-1:0];
    end

    // Font memory access
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [YW-1:0]     y_rd;
    logic [PIXY_W-1:0] rd_full;
    logic [AW-1:0]     ram_raddr;
    logic [FONT_W-1:0] ram_rdata;
    logic              blank;

    always_comb begin
        ram_we    = i_cmd.exec && (r_item.mode == MODE_FONT)
                    && ({1'b0, r_item.write_index} < PIXY_W'(FONT_BYTES));
        ram_waddr = r_item.write_index[AW-1:0];
        y_rd      = i_cmd.y_inc ? (r_y + YW'(1)) : r_y;
        rd_full   = PIXY_W'(PIXY_W'(cur_code) * PIXY_W'(FONT_HEIGHT) + PIXY_W'(y_rd));
        ram_raddr = rd_full[AW-1:0];
        blank     = ({1'b0, cur_code} >= 9'(GLYPH_COUNT));
    end

    btc_ram #(
        .WIDTH (FONT_W),
        .DEPTH (FONT_BYTES)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_item.write_data[FONT_W-1:0]),
        .i_re    (i_cmd.read),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Pixel position of the current row
    logic [COLS_W-1:0] col_sum;
    logic [ROWS_W-1:0] row_sum;

    always_comb begin
        col_sum = {1'b0, r_cur_col} + {1'b0, r_column_offset};
        row_sum = {1'b0, r_cur_row} + {1'b0, r_row_offset};
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_columns  <= TEXT_COLUMNS_RESET;
            r_text_rows     <= TEXT_ROWS_RESET;
            r_column_offset <= '0;
            r_row_offset    <= '0;
            r_back_color    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEXT_COLUMNS: r_text_columns  <= i_cfg_data[COLS_W-1:0];
                REG_TEXT_ROWS:    r_text_rows     <= i_cfg_data[ROWS_W-1:0];
                REG_COL_OFFSET:   r_column_offset <= i_cfg_data[COL_W-1:0];
                REG_ROW_OFFSET:   r_row_offset    <= i_cfg_data[ROW_W-1:0];
                REG_BACK_COLOR:   r_back_color    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Console state, plan and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_fore    <= FORE_RESET;
            r_pending <= 1'b0;
            r_has_a   <= 1'b0;
            r_has_b   <= 1'b0;
            r_y       <= '0;
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                r_palette[i] <= PALETTE_RESET[i];
            end
        end else begin
            if (i_cmd.exec) begin
                unique case (r_item.mode)
                    MODE_CHAR: begin
                        r_pending <= is_at && !r_item.string_end;
                        r_has_a   <= n_has_a;
                        r_has_b   <= n_has_b;
                        r_code_a  <= n_code_a;
                        r_code_b  <= n_code_b;
                        if (r_pending && is_digit) begin
                            r_fore <= r_palette[r_item.char_code[PAL_IW-1:0]];
                        end
                    end
                    MODE_PALETTE: begin
                        if (r_item.write_index < WIDX_W'(PALETTE_SIZE)) begin
                            r_palette[r_item.write_index[PAL_IW-1:0]] <= r_item.write_data;
                        end
                    end
                    MODE_CURSOR: begin
                        r_cur_col <= r_item.set_column;
                        r_cur_row <= r_item.set_row;
                    end
                    MODE_FORE: r_fore <= r_item.write_data;
                    default: ;
                endcase
            end else if (i_cmd.cur_step) begin
                r_cur_col <= step_col;
                r_cur_row <= step_row;
            end

            if (i_cmd.y_clr) begin
                r_y <= '0;
            end else if (i_cmd.y_inc) begin
                r_y <= r_y + YW'(1);
            end
        end
    end

    // Output stage: filled on load, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.pixel_x    <= {col_sum, 3'b000};
            r_out_item.pixel_y    <= PIXY_W'(PIXY_W'(row_sum) * PIXY_W'(FONT_HEIGHT)
                                     + PIXY_W'(r_y));
            r_out_item.row_bits   <= blank ? '0 : ram_rdata;
            r_out_item.fore_color <= r_fore;
            r_out_item.back_color <= r_back_color;
            r_out_item.last_row   <= y_last && (i_cmd.slot_b || !b_drawn);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_stat.is_char  = (r_item.mode == MODE_CHAR);
        o_stat.cur_has  = cur_has;
        o_stat.cur_nl   = cur_nl;
        o_stat.has_b    = r_has_b;
        o_stat.y_last   = y_last;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end
endmodule

// ----- hdl/btc_controller.sv -----
module btc_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  btc_pkg::t_stat i_stat,
    output btc_pkg::t_cmd  o_cmd
);
    import btc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUT,
        S_ROW
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_slot;
    logic   n_slot;
    t_cmd   cmd;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        cmd        = '0;
        cmd.slot_b = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec  = 1'b1;
                cmd.y_clr = 1'b1;
                n_slot    = 1'b0;
                n_state   = i_stat.is_char ? S_PUT : S_IDLE;
            end
            S_PUT: begin
                priority if (!i_stat.cur_has) begin
                    n_state = S_IDLE;
                end else if (i_stat.cur_nl) begin
                    // newline moves the cursor and draws nothing
                    cmd.cur_step = 1'b1;
                    if (!r_slot && i_stat.has_b) begin
                        n_slot = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd.read = 1'b1;
                    n_state  = S_ROW;
                end
            end
            S_ROW: begin
                // row data sits in the font RAM register until the output stage frees
                if (i_stat.out_free) begin
                    cmd.load = 1'b1;
                    if (i_stat.y_last) begin
                        cmd.cur_step = 1'b1;
                        cmd.y_clr    = 1'b1;
                        if (!r_slot && i_stat.has_b) begin
                            n_slot  = 1'b1;
                            n_state = S_PUT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        cmd.y_inc = 1'b1;
                        cmd.read  = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and slot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    // A row is loaded only into a free output stage
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> i_stat.out_free)
        else $error("row loaded into a busy output stage");

    // A new read while rows are in flight would overwrite unloaded data
    a_read_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.read && (r_state == S_ROW)) |-> cmd.load)
        else $error("font read overwrote a pending row");

    // Newlines never touch the font memory
    a_no_nl_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.read |-> !i_stat.cur_nl)
        else $error("font read for a newline");

    // An accepted transaction is executed in the next cycle
    a_latch_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.latch |=> cmd.exec)
        else $error("accepted transaction not executed");
endmodule

// ----- hdl/bitmap_text_console_renderer.sv -----
// Channel    Dir  Signals                       Transaction
// i_in       in   valid, ready, data            one input item, valid && ready
// o_out      out  valid, ready, data            one glyph row result, valid && ready
// i_cfg_*    in   i_cfg_we, i_cfg_index, data   register write when i_cfg_we is high
//
// Each item is latched in S_IDLE and executed in S_EXEC; a newline then steps the cursor
// in S_PUT; a drawn character reads in S_PUT, then gives one result per cycle from the font RAM
// row loop in S_ROW while the output is free; a pending '@' and a character are drawn in turn.
// Output backpressure stalls the row loop; the RAM read register holds the row meanwhile.
// Reset is synchronous, active low; the font RAM is not cleared and holds garbage until written.
module bitmap_text_console_renderer #(
    parameter int FONT_HEIGHT = btc_pkg::FONT_HEIGHT_DEF,
    parameter int GLYPH_COUNT = btc_pkg::GLYPH_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    btc_in_if.sink                        i_in,
    btc_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btc_pkg::DATA_W-1:0]    i_cfg_data
);
    import btc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    btc_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    btc_datapath #(
        .FONT_HEIGHT (FONT_HEIGHT),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.data)
    );
endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import btc_pkg::*;

    localparam int FH           = FONT_HEIGHT_DEF;
    localparam int GC           = GLYPH_COUNT_DEF;
    localparam int FONT_BYTES   = GC * FH;
    localparam int FA_W         = $clog2(FONT_BYTES);
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int SEGMENTS     = 7;
    localparam int RAND_PER_SEG = 20;
    // longest item is a pending '@' plus a drawn char
    localparam int DRAIN_CYCLES = 2 * FH + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // modes the block ignores
    localparam t_mode MODE_SPARE_FIRST = 3'd5;
    localparam t_mode MODE_SPARE_LAST  = 3'd7;

    // glyphs loaded into the font; every drawn code comes from this set
    localparam int GLYPH_N = 14;
    localparam logic [CHAR_W-1:0] GLYPH_SET [GLYPH_N] = '{
        8'h00, 8'hFF, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,   // 0..5
        8'h40, 8'h41, 8'h42, 8'h43, 8'h5A, 8'h71                  // @ A B C Z q
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    btc_in_if  cmd_ch ();
    btc_out_if row_ch ();

    bitmap_text_console_renderer #(
        .FONT_HEIGHT(FH),
        .GLYPH_COUNT(GC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_ch),
        .o_out      (row_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // stimulus and expected glyph rows
    t_in_item  console_cmd_q [$];
    t_out_item glyph_row_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;

    // console state as the block should hold it
    logic [COLS_W-1:0] text_cols;
    logic [ROWS_W-1:0] text_rows;
    logic [COL_W-1:0]  col_offset;
    logic [ROW_W-1:0]  row_offset;
    logic [DATA_W-1:0] back_color;
    logic [COL_W-1:0]  cur_col    = '0;
    logic [ROW_W-1:0]  cur_row    = '0;
    logic [DATA_W-1:0] fore_color = FORE_RESET;
    logic              at_pending = 1'b0;
    logic [DATA_W-1:0] palette [PALETTE_SIZE] = PALETTE_RESET;
    logic [FONT_W-1:0] font_mem [FONT_BYTES];

    // rows produced by the transaction being rendered
    t_out_item row_buf [2*FH];
    int        row_cnt;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------

    // column wrap pulls the row along; row wraps at text_rows or past 255
    task automatic wrap_cursor(input int col, input int row);
        if (col >= int'(text_cols) || col > 511) begin
            col = 0;
            row = row + 1;
        end
        if (row >= int'(text_rows) || row > 255)
            row = 0;
        cur_col = COL_W'(col);
        cur_row = ROW_W'(row);
    endtask

    task automatic emit_glyph(input logic [CHAR_W-1:0] code);
        int        nxt_row;
        int        px;
        int        py;
        int        y;
        t_out_item r;
        if (code == CH_NL) begin
            nxt_row = int'(cur_row) + 1;
            if (nxt_row >= int'(text_rows) || nxt_row > 255)
                nxt_row = 0;
            wrap_cursor(0, nxt_row);
        end else begin
            px = (int'(cur_col) + int'(col_offset)) * 8;
            py = (int'(cur_row) + int'(row_offset)) * FH;
            for (y = 0; y < FH; y++) begin
                r.pixel_x    = px[PIXX_W-1:0];
                r.pixel_y    = PIXY_W'(py + y);
                r.row_bits   = font_mem[FA_W'(int'(code) * FH + y)];
                r.fore_color = fore_color;
                r.back_color = back_color;
                r.last_row   = 1'b0;
                row_buf[row_cnt] = r;
                row_cnt++;
            end
            wrap_cursor(int'(cur_col) + 1, int'(cur_row));
        end
    endtask

    task automatic render_item(input t_in_item it);
        logic draw_follower;
        int   k;
        row_cnt = 0;
        case (it.mode)
            MODE_CHAR: begin
                draw_follower = 1'b1;
                if (at_pending) begin
                    at_pending = 1'b0;
                    if (it.char_code >= CH_ZERO && it.char_code <= CH_FOUR) begin
                        fore_color    = palette[PAL_IW'(it.char_code - CH_ZERO)];
                        draw_follower = 1'b0;
                    end else begin
                        emit_glyph(CH_AT);
                    end
                end
                if (draw_follower) begin
                    if (it.char_code == CH_AT)
                        at_pending = 1'b1;
                    else
                        emit_glyph(it.char_code);
                end
                // flush a dangling '@' at the end of a string
                if (it.string_end && at_pending) begin
                    at_pending = 1'b0;
                    emit_glyph(CH_AT);
                end
            end
            MODE_FONT: begin
                if (it.write_index < FONT_BYTES)
                    font_mem[it.write_index[FA_W-1:0]] = it.write_data[FONT_W-1:0];
            end
            MODE_PALETTE: begin
                if (it.write_index < PALETTE_SIZE)
                    palette[it.write_index[PAL_IW-1:0]] = it.write_data;
            end
            MODE_CURSOR: begin
                cur_col = it.set_column;
                cur_row = it.set_row;
            end
            MODE_FORE: begin
                fore_color = it.write_data;
            end
            default: ;
        endcase
        if (row_cnt > 0)
            row_buf[row_cnt-1].last_row = 1'b1;
        for (k = 0; k < row_cnt; k++)
            glyph_row_q.push_back(row_buf[k]);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_glyph_row(input t_out_item got);
        t_out_item want;
        if (glyph_row_q.size() == 0) begin
            report_mismatch($sformatf("unexpected glyph row x=%0d y=%0d",
                                      got.pixel_x, got.pixel_y));
        end else begin
            want = glyph_row_q.pop_front();
            check_field("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
            check_field("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
            check_field("row_bits", 32'(got.row_bits), 32'(want.row_bits));
            check_field("fore_color", got.fore_color, want.fore_color);
            check_field("back_color", got.back_color, want.back_color);
            check_field("last_row", 32'(got.last_row), 32'(want.last_row));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one transaction per accepted handshake, model updated on accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_ch.valid)
                render_item(cmd_ch.data);
            if (console_cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.data  <= console_cmd_q.pop_front();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check accepted rows, stall the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_ch.ready <= 1'b0;
        end else begin
            if (row_ch.valid && row_ch.ready)
                check_glyph_row(row_ch.data);
            row_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // all fields random, then the mode forced
    function automatic t_in_item rand_item(input t_mode m);
        logic [95:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        it.mode       = m;
        it.string_end = ($urandom_range(4) == 0);
        return it;
    endfunction

    function automatic t_in_item char_item(input logic [CHAR_W-1:0] code,
                                           input logic last);
        t_in_item it;
        it = rand_item(MODE_CHAR);
        it.char_code  = code;
        it.string_end = last;
        return it;
    endfunction

    // drawn codes stay inside the loaded glyph set
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(9))
            0:       return CH_NL;
            1:       return CH_AT;
            2:       return CHAR_W'(CH_ZERO + $urandom_range(4));
            3:       return CH_FOUR + 8'd1;
            default: return GLYPH_SET[$urandom_range(GLYPH_N - 1)];
        endcase
    endfunction

    task automatic queue_random(input int n);
        int       i;
        t_in_item it;
        for (i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1: begin
                    console_cmd_q.push_back(rand_item(MODE_FONT));
                end
                2: begin
                    it = rand_item(MODE_PALETTE);
                    if ($urandom_range(3) != 0)
                        it.write_index = WIDX_W'($urandom_range(PALETTE_SIZE + 2));
                    console_cmd_q.push_back(it);
                end
                3: begin
                    it = rand_item(MODE_CURSOR);
                    if ($urandom_range(1) == 0) begin
                        it.set_column = COL_W'($urandom_range(7));
                        it.set_row    = ROW_W'($urandom_range(5));
                    end
                    console_cmd_q.push_back(it);
                end
                4: begin
                    console_cmd_q.push_back(rand_item(MODE_FORE));
                end
                5: begin
                    console_cmd_q.push_back(rand_item(
                        MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST))));
                end
                6, 7, 8: begin
                    // color escape: '@' followed by a palette digit
                    console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                    console_cmd_q.push_back(char_item(CHAR_W'(CH_ZERO + $urandom_range(4)),
                                                      $urandom_range(3) == 0));
                end
                default: begin
                    console_cmd_q.push_back(char_item(pick_char(), $urandom_range(4) == 0));
                end
            endcase
        end
    endtask

    task automatic program_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_TEXT_COLUMNS: text_cols  = val[COLS_W-1:0];
            REG_TEXT_ROWS:    text_rows  = val[ROWS_W-1:0];
            REG_COL_OFFSET:   col_offset = val[COL_W-1:0];
            REG_ROW_OFFSET:   row_offset = val[ROW_W-1:0];
            REG_BACK_COLOR:   back_color = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int cols, input int rows, input int coff,
                                 input int roff, input logic [DATA_W-1:0] bg);
        program_reg(REG_TEXT_COLUMNS, cols);
        program_reg(REG_TEXT_ROWS, rows);
        program_reg(REG_COL_OFFSET, coff);
        program_reg(REG_ROW_OFFSET, roff);
        program_reg(REG_BACK_COLOR, bg);
    endtask

    // all stimulus accepted, all rows seen, then let the block settle
    task automatic wait_drained();
        while (console_cmd_q.size() != 0 || cmd_ch.valid || glyph_row_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int       seg;
        int       gi;
        int       ri;
        t_in_item it;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        text_cols  = TEXT_COLUMNS_RESET;
        text_rows  = TEXT_ROWS_RESET;
        col_offset = '0;
        row_offset = '0;
        back_color = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            // receiver-heavy idling, then sender-heavy, then none
            if (seg < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 59;
            end else if (seg < 5) begin
                send_idle_pct = 59;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (seg)
                0: ;  // reset values of all registers
                1: apply_setting(1023, 511, 511, 255, 32'hFFFF_FFFF);
                2: apply_setting(0, 0, 0, 0, 32'h0);
                3: apply_setting(1, 1, $urandom_range(511), $urandom_range(255), $urandom);
                4: apply_setting($urandom_range(9, 2), $urandom_range(6, 2),
                                 $urandom_range(511), $urandom_range(255), $urandom);
                5: apply_setting(512, 256, $urandom_range(511), $urandom_range(255),
                                 $urandom);
                default: apply_setting($urandom_range(512, 1), $urandom_range(256, 1),
                                       $urandom_range(511), $urandom_range(255),
                                       $urandom);
            endcase

            if (seg == 0) begin
                // load every row of the glyphs that the stimulus draws
                for (gi = 0; gi < GLYPH_N; gi++) begin
                    for (ri = 0; ri < FH; ri++) begin
                        it = rand_item(MODE_FONT);
                        it.write_index = WIDX_W'(int'(GLYPH_SET[gi]) * FH + ri);
                        console_cmd_q.push_back(it);
                    end
                end

                // reset colors and plain characters at the code extremes
                console_cmd_q.push_back(char_item(8'h00, 1'b0));
                console_cmd_q.push_back(char_item(8'hFF, 1'b0));
                console_cmd_q.push_back(char_item(CH_NL, 1'b0));
                // escape to a palette color
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item(CH_ZERO + 8'd3, 1'b0));
                console_cmd_q.push_back(char_item("A", 1'b0));
                // '@' with a non-digit follower draws both
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item("Z", 1'b0));
                // '@' '@' re-arms the escape; then a digit just past the palette
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item(CH_FOUR + 8'd1, 1'b0));
                // pending '@' flushed at string end
                console_cmd_q.push_back(char_item(CH_AT, 1'b1));
                console_cmd_q.push_back(char_item("q", 1'b1));
                // escape stays pending across a foreground write
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(rand_item(MODE_FORE));
                console_cmd_q.push_back(char_item(CH_ZERO, 1'b0));
                // two glyphs from one transaction
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item(CH_AT, 1'b1));
                // palette writes in range and out of range
                it = rand_item(MODE_PALETTE);
                it.write_index = WIDX_W'(PALETTE_SIZE - 1);
                console_cmd_q.push_back(it);
                it = rand_item(MODE_PALETTE);
                it.write_index = WIDX_W'($urandom_range(8191, PALETTE_SIZE));
                console_cmd_q.push_back(it);
                console_cmd_q.push_back(char_item(CH_AT, 1'b0));
                console_cmd_q.push_back(char_item(CH_FOUR, 1'b0));
                // cursor set to the far corner, past the line limits
                it = rand_item(MODE_CURSOR);
                it.set_column = '1;
                it.set_row    = '1;
                it.string_end = 1'b1;
                console_cmd_q.push_back(it);
                console_cmd_q.push_back(char_item("B", 1'b0));
                // ignored mode, then an all-ones foreground
                console_cmd_q.push_back(rand_item(MODE_SPARE_LAST));
                it = rand_item(MODE_FORE);
                it.write_data = '1;
                console_cmd_q.push_back(it);
                console_cmd_q.push_back(char_item("C", 1'b1));
            end

            queue_random(RAND_PER_SEG);
            wait_drained();
        end

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/btc_pkg.sv
hdl/btc_if.sv
hdl/btc_ram.sv
hdl/btc_datapath.sv
hdl/btc_controller.sv
hdl/bitmap_text_console_renderer.sv
bench/tb_top.sv
